[rtl/lzm_pkg.sv]
// Shared types and constants for the layer z-order manager.
package lzm_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int IDX_W      = $clog2(MAX_LAYERS);
    localparam int HGT_W      = IDX_W + 1;     // heights -1 .. MAX_LAYERS-1
    localparam int OP_W       = 3;
    localparam int REQ_W      = 9;
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 11;
    localparam int RECT_W     = 13;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ALLOC  = 3'd0;
    localparam op_t OP_SIZE   = 3'd1;
    localparam op_t OP_HEIGHT = 3'd2;
    localparam op_t OP_MOVE   = 3'd3;
    localparam op_t OP_FREE   = 3'd4;

    localparam logic signed [HGT_W-1:0] HIDDEN = -1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_RECT_X,
        ST_RECT_Y,
        ST_FINISH
    } state_t;

    // One axis of a span: two start coordinates and an extent.
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic [SIZE_W-1:0]         size;
    } span_req_t;

    // Inclusive low and high ends of the covering span.
    typedef struct packed {
        logic signed [RECT_W-1:0] lo;
        logic signed [RECT_W-1:0] hi;
    } span_rsp_t;

endpackage

[rtl/lzm_span_unit.sv]
// Shared compare and add unit: covering span of two equal-length segments.
module lzm_span_unit import lzm_pkg::*; (
    input  span_req_t req,
    output span_rsp_t rsp
);

    logic                      a_lt_b;
    logic signed [COORD_W-1:0] lo_c;
    logic signed [COORD_W-1:0] hi_c;
    logic        [RECT_W-1:0]  lo_ext;
    logic        [RECT_W-1:0]  hi_ext;

    always_comb begin
        a_lt_b = $signed(req.a) < $signed(req.b);
        lo_c   = a_lt_b ? req.a : req.b;
        hi_c   = a_lt_b ? req.b : req.a;
        lo_ext = {{(RECT_W-COORD_W){lo_c[COORD_W-1]}}, lo_c};
        hi_ext = {{(RECT_W-COORD_W){hi_c[COORD_W-1]}}, hi_c};
        rsp.lo = lo_ext;
        // inclusive end: start + extent - 1
        rsp.hi = hi_ext + RECT_W'(req.size) - RECT_W'(1);
    end

endmodule

[rtl/layer_zorder_manager_core.sv]
// Layer z-order manager: slot table, stacking list and redraw rectangles.
//
// Each input word is one window-system command (allocate, set size, set
// height, move, free) and yields exactly one result word. The core works
// on one command at a time: s_tready is high only while idle. Allocate
// scans the slots for a free one (1..16 slots scanned); set size,
// unknown codes and moving a hidden layer go straight to the result;
// moving a visible layer also builds the rectangle, and a height change
// or freeing a visible layer first shifts 0..15 stacking-list entries
// and places the layer. The sequencer walks the stacking list and the
// free-slot scan one entry per cycle; the shared span unit gives the
// rectangle's x span, then its y span. A finished result sits in the
// output register; the next command is taken while it waits, and the
// core only stalls at that command's end if the old word is still waiting.
module layer_zorder_manager_core import lzm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, from bit 0: layer_index, new_height, pos_x, pos_y, size_x,
    // size_y, zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // s_tuser: operation
    input  logic [2:0]  s_tuser,
    // m_tdata, from bit 0: status, allocated_slot, redraw, rect_left,
    // rect_top, rect_right, rect_bottom, top_height, applied_height,
    // zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    // input word layout
    localparam int IDX_LSB  = 0;
    localparam int REQ_LSB  = IDX_LSB + IDX_W;
    localparam int PX_LSB   = REQ_LSB + REQ_W;
    localparam int PY_LSB   = PX_LSB + COORD_W;
    localparam int SX_LSB   = PY_LSB + COORD_W;
    localparam int SY_LSB   = SX_LSB + SIZE_W;
    localparam int OUT_BITS = 1 + IDX_W + 1 + 4 * RECT_W + 2 * HGT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_LAYERS - 1);

    state_t state_reg, state_next;

    // latched command
    op_t                       op_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [REQ_W-1:0]   req_h_reg;
    logic signed [COORD_W-1:0] px_reg;
    logic signed [COORD_W-1:0] py_reg;
    logic [SIZE_W-1:0]         sx_reg;
    logic [SIZE_W-1:0]         sy_reg;

    // slot table and stacking list
    logic [IDX_W-1:0]          order_reg  [MAX_LAYERS];
    logic signed [HGT_W-1:0]   height_reg [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]     in_use_reg;
    logic signed [COORD_W-1:0] left_reg   [MAX_LAYERS];
    logic signed [COORD_W-1:0] ypos_reg   [MAX_LAYERS];
    logic [SIZE_W-1:0]         width_reg  [MAX_LAYERS];
    logic [SIZE_W-1:0]         tall_reg   [MAX_LAYERS];
    logic signed [HGT_W-1:0]   top_idx_reg;

    // list walk control
    logic [IDX_W-1:0]          dst_reg;
    logic [IDX_W-1:0]          end_reg;
    logic                      up_reg;
    logic                      hide_reg;
    logic                      grow_reg;
    logic                      move_reg;
    logic                      free_reg;
    logic signed [HGT_W-1:0]   h_reg;

    // result being built
    logic                      res_status_reg;
    logic [IDX_W-1:0]          res_slot_reg;
    logic                      res_redraw_reg;
    logic signed [RECT_W-1:0]  res_l_reg;
    logic signed [RECT_W-1:0]  res_t_reg;
    logic signed [RECT_W-1:0]  res_r_reg;
    logic signed [RECT_W-1:0]  res_b_reg;

    // output register
    logic                      m_valid_reg;
    logic [OUT_W-1:0]          m_data_reg;

    // decode-time values
    logic                      slot_ok;
    logic signed [HGT_W-1:0]   old_h;
    logic signed [REQ_W:0]     req_ext;
    logic signed [REQ_W:0]     top_ext;
    logic signed [REQ_W:0]     lim_ext;
    logic signed [REQ_W:0]     clamp_a;
    logic signed [HGT_W-1:0]   tgt_h;
    logic signed [HGT_W-1:0]   top_inc;
    logic                      go_shift;

    // walk step
    logic [IDX_W-1:0]          src_idx;
    logic [IDX_W-1:0]          mv_slot;
    logic                      shift_more;
    logic signed [HGT_W-1:0]   applied_h;

    // control outputs
    logic                      out_load;

    span_req_t                 span_req;
    span_rsp_t                 span_rsp;

    lzm_span_unit u_span (
        .req (span_req),
        .rsp (span_rsp)
    );

    always_comb begin
        slot_ok = in_use_reg[idx_reg];
        old_h   = height_reg[idx_reg];
        req_ext = {req_h_reg[REQ_W-1], req_h_reg};
        top_ext = {{(REQ_W+1-HGT_W){top_idx_reg[HGT_W-1]}}, top_idx_reg};
        // a visible layer tops out at top_index, a hidden one may go above
        lim_ext = old_h[HGT_W-1] ? top_ext + (REQ_W+1)'(1) : top_ext;
        clamp_a = (req_ext > lim_ext) ? lim_ext : req_ext;
        if (op_reg == OP_FREE) begin
            tgt_h = HIDDEN;
        end else if (clamp_a[REQ_W]) begin
            tgt_h = HIDDEN;
        end else begin
            tgt_h = clamp_a[HGT_W-1:0];
        end
        top_inc  = top_idx_reg + HGT_W'(1);
        go_shift = slot_ok && (((op_reg == OP_HEIGHT) && (old_h != tgt_h)) ||
                               ((op_reg == OP_FREE) && !old_h[HGT_W-1]));

        src_idx    = up_reg ? dst_reg + IDX_W'(1) : dst_reg - IDX_W'(1);
        mv_slot    = order_reg[src_idx];
        shift_more = up_reg ? (dst_reg < end_reg) : (dst_reg > end_reg);
        applied_h  = (op_reg == OP_ALLOC) ? HIDDEN : height_reg[idx_reg];
    end

    // x axis then y axis through the one span unit
    always_comb begin
        if (state_reg == ST_RECT_Y) begin
            span_req.a    = ypos_reg[idx_reg];
            span_req.b    = move_reg ? py_reg : ypos_reg[idx_reg];
            span_req.size = tall_reg[idx_reg];
        end else begin
            span_req.a    = left_reg[idx_reg];
            span_req.b    = move_reg ? px_reg : left_reg[idx_reg];
            span_req.size = width_reg[idx_reg];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (op_reg)
                    OP_ALLOC:           state_next = ST_SCAN;
                    OP_HEIGHT, OP_FREE: state_next = go_shift ? ST_SHIFT : ST_FINISH;
                    OP_MOVE: begin
                        state_next = (slot_ok && !old_h[HGT_W-1]) ? ST_RECT_X
                                                                   : ST_FINISH;
                    end
                    default:            state_next = ST_FINISH;
                endcase
            end
            ST_SCAN: begin
                if (!in_use_reg[dst_reg] || (dst_reg == LAST_SLOT)) state_next = ST_FINISH;
            end
            ST_SHIFT: begin
                if (!shift_more) state_next = ST_PLACE;
            end
            ST_PLACE:  state_next = ST_RECT_X;
            ST_RECT_X: state_next = ST_RECT_Y;
            ST_RECT_Y: state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_load) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            top_idx_reg <= HIDDEN;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_LAYERS; i++) begin
                height_reg[i] <= HIDDEN;
                left_reg[i]   <= '0;
                ypos_reg[i]   <= '0;
                width_reg[i]  <= '0;
                tall_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        idx_reg   <= s_tdata[IDX_LSB +: IDX_W];
                        req_h_reg <= s_tdata[REQ_LSB +: REQ_W];
                        px_reg    <= s_tdata[PX_LSB +: COORD_W];
                        py_reg    <= s_tdata[PY_LSB +: COORD_W];
                        sx_reg    <= s_tdata[SX_LSB +: SIZE_W];
                        sy_reg    <= s_tdata[SY_LSB +: SIZE_W];
                    end
                end
                ST_DECODE: begin
                    res_status_reg <= 1'b0;
                    res_slot_reg   <= '0;
                    res_redraw_reg <= 1'b0;
                    res_l_reg      <= '0;
                    res_t_reg      <= '0;
                    res_r_reg      <= '0;
                    res_b_reg      <= '0;
                    move_reg       <= (op_reg == OP_MOVE);
                    free_reg       <= (op_reg == OP_FREE);
                    hide_reg       <= 1'b0;
                    grow_reg       <= 1'b0;
                    h_reg          <= tgt_h;
                    dst_reg        <= '0;
                    case (op_reg)
                        OP_SIZE: begin
                            if (slot_ok) begin
                                width_reg[idx_reg] <= sx_reg;
                                tall_reg[idx_reg]  <= sy_reg;
                            end
                        end
                        OP_MOVE: begin
                            // hidden layer: just reposition, no rectangle
                            if (slot_ok && old_h[HGT_W-1]) begin
                                left_reg[idx_reg] <= px_reg;
                                ypos_reg[idx_reg] <= py_reg;
                            end
                        end
                        OP_HEIGHT, OP_FREE: begin
                            if (slot_ok && (op_reg == OP_FREE) && old_h[HGT_W-1]) begin
                                in_use_reg[idx_reg] <= 1'b0;
                            end
                            if (old_h > tgt_h) begin
                                dst_reg <= old_h[IDX_W-1:0];
                                if (!tgt_h[HGT_W-1]) begin
                                    // lowered: entries in between move up
                                    up_reg  <= 1'b0;
                                    end_reg <= tgt_h[IDX_W-1:0];
                                end else begin
                                    // hidden: close the gap down to the top
                                    up_reg   <= 1'b1;
                                    end_reg  <= top_idx_reg[IDX_W-1:0];
                                    hide_reg <= 1'b1;
                                end
                            end else if (!old_h[HGT_W-1]) begin
                                // raised: entries in between move down
                                up_reg  <= 1'b1;
                                dst_reg <= old_h[IDX_W-1:0];
                                end_reg <= tgt_h[IDX_W-1:0];
                            end else begin
                                // shown: open a gap, list grows by one
                                up_reg   <= 1'b0;
                                dst_reg  <= top_inc[IDX_W-1:0];
                                end_reg  <= tgt_h[IDX_W-1:0];
                                grow_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_SCAN: begin
                    if (!in_use_reg[dst_reg]) begin
                        in_use_reg[dst_reg] <= 1'b1;
                        height_reg[dst_reg] <= HIDDEN;
                        res_slot_reg        <= dst_reg;
                    end else if (dst_reg == LAST_SLOT) begin
                        res_status_reg <= 1'b1;
                    end else begin
                        dst_reg <= dst_reg + IDX_W'(1);
                    end
                end
                ST_SHIFT: begin
                    if (shift_more) begin
                        order_reg[dst_reg]  <= mv_slot;
                        height_reg[mv_slot] <= {1'b0, dst_reg};
                        dst_reg             <= src_idx;
                    end
                end
                ST_PLACE: begin
                    res_redraw_reg <= 1'b1;
                    if (hide_reg) begin
                        height_reg[idx_reg] <= HIDDEN;
                        top_idx_reg         <= top_idx_reg - HGT_W'(1);
                        if (free_reg) in_use_reg[idx_reg] <= 1'b0;
                    end else begin
                        order_reg[h_reg[IDX_W-1:0]] <= idx_reg;
                        height_reg[idx_reg]         <= h_reg;
                        if (grow_reg) top_idx_reg <= top_inc;
                    end
                end
                ST_RECT_X: begin
                    res_redraw_reg <= 1'b1;
                    res_l_reg      <= span_rsp.lo;
                    res_r_reg      <= span_rsp.hi;
                end
                ST_RECT_Y: begin
                    res_t_reg <= span_rsp.lo;
                    res_b_reg <= span_rsp.hi;
                    if (move_reg) begin
                        left_reg[idx_reg] <= px_reg;
                        ypos_reg[idx_reg] <= py_reg;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        m_data_reg <= OUT_W'({applied_h, top_idx_reg,
                                              res_b_reg, res_r_reg, res_t_reg, res_l_reg,
                                              res_redraw_reg, res_slot_reg, res_status_reg});
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // visible-slot map for the list invariant
    logic [MAX_LAYERS-1:0] vis_vec;
    always_comb begin
        for (int i = 0; i < MAX_LAYERS; i++) begin
            vis_vec[i] = !height_reg[i][HGT_W-1];
        end
    end

    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted word did not enter decode");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |->
            (up_reg ? (dst_reg <= end_reg) : (dst_reg >= end_reg)))
        else $error("list walk overran its end point");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_valid_reg && !m_tready) |=>
            (state_reg == ST_FINISH && m_valid_reg))
        else $error("pending result word was overwritten");

    a_list_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(vis_vec) == int'(top_idx_reg) + 1))
        else $error("visible layer count does not match top index");

endmodule
